[src/msr_pkg.sv]
// Package for the masked share refresh block.
// Holds the shared widths, generator seeds and the queue entry types.
// No dependencies.
package msr_pkg;

    // Field widths fixed by the interface; share_index carries the low bits
    // of the set position.
    localparam int IDX_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 5;
    localparam int DRAW_W  = 32;

    // Largest number of shares in one masked byte, and the widths that follow.
    localparam int MAX_SHARES = 16;
    localparam int POS_W      = $clog2(MAX_SHARES);
    localparam int CNT_W      = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;

    // Generator seeds.
    localparam logic [31:0] SEED_X = 32'd123456789;
    localparam logic [31:0] SEED_Y = 32'd362436069;
    localparam logic [31:0] SEED_Z = 32'd521288629;

    // Reset value of the share count register.
    localparam logic [CFG_W-1:0] SHARE_COUNT_RESET = CFG_W'(2);

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One queued record: a first result and an optional closing result.
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic [DRAW_W-1:0] draws;
        logic              has_tail;
        logic [BYTE_W-1:0] tail_value;
    } entry_t;

    // Write side of the queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Status of the back end.
    typedef struct packed {
        logic tail_pending;
    } back_status_t;

endpackage

[src/msr_front.sv]
// Front end of the masked share refresh block: accepts share items, steps
// the xorshift96 generator and builds queue records. Depends on msr_pkg.
module msr_front import msr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [BYTE_W-1:0] share_value,
    output push_t             push
);

    logic [CFG_W-1:0]  share_count_reg;
    logic [31:0]       gen_x_reg, gen_x_next;
    logic [31:0]       gen_y_reg, gen_y_next;
    logic [31:0]       gen_z_reg, gen_z_next;
    logic [DRAW_W-1:0] draw_total_reg, draw_total_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [BYTE_W-1:0] held_reg, held_next;

    logic [CNT_W-1:0]  count_eff;
    logic [31:0]       x1, x2, x3, z_new;
    logic [BYTE_W-1:0] rand_byte;
    logic [BYTE_W-1:0] held_mixed;
    logic [CNT_W-1:0]  next_pos_wide;
    logic              closes;

    // Clamp the configured count into the supported range.
    always_comb
    begin
        if (share_count_reg == '0)
            count_eff = CNT_W'(1);
        else if (CNT_W'(share_count_reg) > CNT_W'(MAX_SHARES))
            count_eff = CNT_W'(MAX_SHARES);
        else
            count_eff = CNT_W'(share_count_reg);
    end

    // One xorshift96 step; the draw is the low byte of the new z.
    always_comb
    begin
        x1        = gen_x_reg ^ (gen_x_reg << 16);
        x2        = x1 ^ (x1 >> 5);
        x3        = x2 ^ (x2 << 1);
        z_new     = x3 ^ gen_y_reg ^ gen_z_reg;
        rand_byte = z_new[BYTE_W-1:0];
    end

    assign held_mixed    = held_reg ^ rand_byte;
    assign next_pos_wide = CNT_W'(position_reg) + CNT_W'(1);
    assign closes        = (next_pos_wide >= count_eff);

    // Classify the item and build the record that goes to the queue.
    always_comb
    begin
        gen_x_next      = gen_x_reg;
        gen_y_next      = gen_y_reg;
        gen_z_next      = gen_z_reg;
        draw_total_next = draw_total_reg;
        position_next   = position_reg;
        held_next       = held_reg;
        push            = '0;
        if (accept)
        begin
            if (position_reg == '0)
            begin
                if (count_eff == CNT_W'(1))
                begin
                    // A single share passes through unchanged and closes the set.
                    push.valid       = 1'b1;
                    push.entry.index = '0;
                    push.entry.value = share_value;
                    push.entry.last  = 1'b1;
                    push.entry.draws = draw_total_reg;
                end
                else
                begin
                    held_next     = share_value;
                    position_next = POS_W'(1);
                end
            end
            else
            begin
                gen_x_next       = gen_y_reg;
                gen_y_next       = gen_z_reg;
                gen_z_next       = z_new;
                draw_total_next  = draw_total_reg + DRAW_W'(1);
                held_next        = held_mixed;
                push.valid       = 1'b1;
                push.entry.index = IDX_W'(position_reg);
                push.entry.value = share_value ^ rand_byte;
                push.entry.last  = 1'b0;
                push.entry.draws = draw_total_reg + DRAW_W'(1);
                push.entry.has_tail   = closes;
                push.entry.tail_value = held_mixed;
                position_next    = closes ? '0 : next_pos_wide[POS_W-1:0];
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_count_reg <= SHARE_COUNT_RESET;
            gen_x_reg       <= SEED_X;
            gen_y_reg       <= SEED_Y;
            gen_z_reg       <= SEED_Z;
            draw_total_reg  <= '0;
            position_reg    <= '0;
            held_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
                share_count_reg <= cfg_data;
            gen_x_reg      <= gen_x_next;
            gen_y_reg      <= gen_y_next;
            gen_z_reg      <= gen_z_next;
            draw_total_reg <= draw_total_next;
            position_reg   <= position_next;
            held_reg       <= held_next;
        end
    end

endmodule

[src/msr_queue.sv]
// Short queue of result records between the front and back ends.
// Depends on msr_pkg.
module msr_queue import msr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push.valid && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/msr_back.sv]
// Back end of the masked share refresh block: drains queue records into the
// output register, emitting the closing share zero as a second item.
// Depends on msr_pkg.
module msr_back import msr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  entry_t            head,
    input  queue_status_t     qstatus,
    output logic              pop,
    output back_status_t      status,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [IDX_W-1:0]  share_index,
    output logic [BYTE_W-1:0] refreshed_value,
    output logic              last,
    output logic [DRAW_W-1:0] draws_so_far
);

    logic              valid_reg, valid_next;
    logic              tail_reg, tail_next;
    logic [BYTE_W-1:0] tail_value_reg, tail_value_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic              last_reg, last_next;
    logic [DRAW_W-1:0] draws_reg, draws_next;
    logic              load;

    assign load = !valid_reg || !result_stall;

    // Choose what the output register holds next.
    always_comb
    begin
        valid_next      = valid_reg;
        tail_next       = tail_reg;
        tail_value_next = tail_value_reg;
        index_next      = index_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        draws_next      = draws_reg;
        pop             = 1'b0;
        if (load)
        begin
            if (tail_reg)
            begin
                // Closing share zero keeps the draw count of its partner.
                valid_next = 1'b1;
                tail_next  = 1'b0;
                index_next = '0;
                value_next = tail_value_reg;
                last_next  = 1'b1;
            end
            else if (!qstatus.empty)
            begin
                pop             = 1'b1;
                valid_next      = 1'b1;
                tail_next       = head.has_tail;
                tail_value_next = head.tail_value;
                index_next      = head.index;
                value_next      = head.value;
                last_next       = head.last;
                draws_next      = head.draws;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tail_reg  <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tail_value_reg <= tail_value_next;
        index_reg      <= index_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
        draws_reg      <= draws_next;
    end

    assign result_valid        = valid_reg;
    assign share_index         = index_reg;
    assign refreshed_value     = value_reg;
    assign last                = last_reg;
    assign draws_so_far        = draws_reg;
    assign status.tail_pending = tail_reg;

endmodule

[src/masked_share_refresh_top.sv]
// Masked share refresh, top level. An accepted share goes through the queue
// into the output register, and the closing share zero follows its partner.
// Throughput: one share per cycle unless the queue is full or output stalls;
// closing shares add items to the single output register draining the queue.
// Reset (rst_n, async, active low) restores the generator seeds, clears the
// draw count, set position and queue, and sets the share count to 2.
module masked_share_refresh_top import msr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  share_count,
    input  logic              share_valid,
    output logic              share_stall,
    input  logic [BYTE_W-1:0] share_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [IDX_W-1:0]  share_index,
    output logic [BYTE_W-1:0] refreshed_value,
    output logic              last,
    output logic [DRAW_W-1:0] draws_so_far
);

    push_t         push;
    entry_t        head;
    queue_status_t qstatus;
    back_status_t  bstatus;
    logic          pop;
    logic          accept;

    // The register is always writable; the input stalls on a full queue.
    assign cfg_ready   = 1'b1;
    assign share_stall = qstatus.full;
    assign accept      = share_valid && !share_stall;

    msr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (share_count),
        .accept      (accept),
        .share_value (share_value),
        .push        (push)
    );

    msr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (qstatus)
    );

    msr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .qstatus         (qstatus),
        .pop             (pop),
        .status          (bstatus),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .share_index     (share_index),
        .refreshed_value (refreshed_value),
        .last            (last),
        .draws_so_far    (draws_so_far)
    );

    // A record is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && qstatus.full))
        else $error("push into full queue");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstatus.empty))
        else $error("pop from empty queue");

    // A pending closing share always sits behind a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        bstatus.tail_pending |-> result_valid)
        else $error("closing share pending without a result");

    // The closing result of a set is always share zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (share_index == '0))
        else $error("last result is not share zero");

endmodule
